// ===== rtl/lulea_level1_route_lookup_macros.svh =====
// Assertion macros shared by the route lookup RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef LULEA_LEVEL1_ROUTE_LOOKUP_MACROS_SVH
`define LULEA_LEVEL1_ROUTE_LOOKUP_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrl_pkg.sv =====
// Shared types and constants for the level-1 route lookup pipeline.
// No dependencies; used by every module of the block except lrl_ram.
package lrl_pkg;

    localparam int DEF_POINTER_DEPTH  = 65536;
    localparam int DEF_NEXT_HOP_DEPTH = 16384;
    localparam int DEF_MAP_RECORDS    = 1024;

    localparam int CODEWORD_DEPTH  = 4096;
    localparam int BASE_DEPTH      = 1024;
    localparam int MAP_LAST_RECORD = 675;
    localparam logic [9:0] DIRECT_MARK = 10'(MAP_LAST_RECORD + 5);
    localparam int HOP_INDEX_W     = 14;

    typedef enum logic [2:0] {
        REQ_LOOKUP = 3'd0,
        REQ_CW_WR  = 3'd1,
        REQ_BASE_WR = 3'd2,
        REQ_MAP_WR = 3'd3,
        REQ_PTR_WR = 3'd4,
        REQ_HOP_WR = 3'd5
    } req_t;

    typedef struct packed {
        req_t        req;
        logic [31:0] dest;
        logic [15:0] idx;
        logic [15:0] word;
        logic [31:0] hop;
    } req_item_t;

    // Item leaving the codeword / base / map half of the pipeline
    typedef struct packed {
        logic        valid;
        req_t        req;
        logic [15:0] idx;
        logic [15:0] word;
        logic [31:0] hop;
        logic        direct;
        logic [5:0]  low6;
        logic [15:0] base;
        logic [3:0]  nib;
    } chunk_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] gateway;
        logic [15:0] route;
        logic        direct;
    } result_t;

endpackage

// ===== rtl/lrl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module lrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

// ===== rtl/lrl_front.sv =====
// Front half of the lookup pipeline: codeword and base tables, then map bytes.
// Depends on lrl_pkg and lrl_ram.
module lrl_front #(
    parameter int MAP_RECORDS = lrl_pkg::DEF_MAP_RECORDS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  lrl_pkg::req_item_t  in_item,
    output lrl_pkg::chunk_item_t chunk
);
    import lrl_pkg::*;

    localparam int MAP_BYTES = MAP_RECORDS * 8;
    localparam int MAP_AW    = $clog2(MAP_BYTES);
    localparam int CW_AW     = $clog2(CODEWORD_DEPTH);
    localparam int BASE_AW   = $clog2(BASE_DEPTH);

    // stage 0: codeword and base table access
    logic               cw_en, cw_we, base_en, base_we, lookup0;
    logic [CW_AW-1:0]   cw_addr;
    logic [BASE_AW-1:0] base_addr;
    logic [15:0]        cw_rdata, base_rdata;

    always_comb
    begin
        lookup0   = in_item.req == REQ_LOOKUP;
        cw_we     = in_item.req == REQ_CW_WR;
        base_we   = in_item.req == REQ_BASE_WR;
        cw_en     = advance && in_valid &&
                    (lookup0 || (cw_we && in_item.idx < 16'(CODEWORD_DEPTH)));
        base_en   = advance && in_valid &&
                    (lookup0 || (base_we && in_item.idx < 16'(BASE_DEPTH)));
        cw_addr   = cw_we ? in_item.idx[CW_AW-1:0] : in_item.dest[31:20];
        base_addr = base_we ? in_item.idx[BASE_AW-1:0] : in_item.dest[31:22];
    end

    lrl_ram #(.WIDTH(16), .DEPTH(CODEWORD_DEPTH)) u_cw_ram (
        .clk   (clk),
        .en    (cw_en),
        .we    (cw_we),
        .addr  (cw_addr),
        .wdata (in_item.word),
        .rdata (cw_rdata)
    );

    lrl_ram #(.WIDTH(16), .DEPTH(BASE_DEPTH)) u_base_ram (
        .clk   (clk),
        .en    (base_en),
        .we    (base_we),
        .addr  (base_addr),
        .wdata (in_item.word),
        .rdata (base_rdata)
    );

    // stage 1: decode codeword, access map bytes
    logic        v1_reg;
    req_t        req1_reg;
    logic [3:0]  pos1_reg;
    logic [15:0] idx1_reg, word1_reg;
    logic [31:0] hop1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            req1_reg  <= in_item.req;
            pos1_reg  <= in_item.dest[19:16];
            idx1_reg  <= in_item.idx;
            word1_reg <= in_item.word;
            hop1_reg  <= in_item.hop;
        end
    end

    logic [9:0]        record1;
    logic              direct1, rec_ok1, map_en, map_we;
    logic [MAP_AW-1:0] map_addr;
    logic [7:0]        map_rdata;

    always_comb
    begin
        record1  = cw_rdata[15:6];
        direct1  = record1 == DIRECT_MARK;
        rec_ok1  = 11'(record1) < 11'(MAP_RECORDS);
        map_we   = req1_reg == REQ_MAP_WR;
        map_en   = advance && v1_reg &&
                   ((req1_reg == REQ_LOOKUP && !direct1 && rec_ok1) ||
                    (map_we && {1'b0, idx1_reg} < 17'(MAP_BYTES)));
        map_addr = map_we ? idx1_reg[MAP_AW-1:0] : MAP_AW'({record1, pos1_reg[3:1]});
    end

    lrl_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map_ram (
        .clk   (clk),
        .en    (map_en),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (word1_reg[7:0]),
        .rdata (map_rdata)
    );

    // stage 2: hold base word and codeword pieces beside the map byte
    logic        v2_reg, pos0_2_reg, direct2_reg, rec_ok2_reg;
    req_t        req2_reg;
    logic [15:0] idx2_reg, word2_reg, base2_reg;
    logic [31:0] hop2_reg;
    logic [5:0]  low6_2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            req2_reg    <= req1_reg;
            idx2_reg    <= idx1_reg;
            word2_reg   <= word1_reg;
            hop2_reg    <= hop1_reg;
            pos0_2_reg  <= pos1_reg[0];
            low6_2_reg  <= cw_rdata[5:0];
            base2_reg   <= base_rdata;
            direct2_reg <= direct1;
            rec_ok2_reg <= rec_ok1;
        end
    end

    always_comb
    begin
        chunk.valid  = v2_reg;
        chunk.req    = req2_reg;
        chunk.idx    = idx2_reg;
        chunk.word   = word2_reg;
        chunk.hop    = hop2_reg;
        chunk.direct = direct2_reg;
        chunk.low6   = low6_2_reg;
        chunk.base   = base2_reg;
        // odd position takes the low nibble; record out of range reads as zero
        if (!rec_ok2_reg)
        begin
            chunk.nib = 4'd0;
        end
        else if (pos0_2_reg)
        begin
            chunk.nib = map_rdata[3:0];
        end
        else
        begin
            chunk.nib = map_rdata[7:4];
        end
    end

endmodule

// ===== rtl/lrl_back.sv =====
// Back half of the lookup pipeline: pointer table, then next-hop table.
// Depends on lrl_pkg and lrl_ram.
module lrl_back #(
    parameter int POINTER_DEPTH  = lrl_pkg::DEF_POINTER_DEPTH,
    parameter int NEXT_HOP_DEPTH = lrl_pkg::DEF_NEXT_HOP_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  lrl_pkg::chunk_item_t chunk,
    output lrl_pkg::result_t     res
);
    import lrl_pkg::*;

    localparam int PTR_AW = $clog2(POINTER_DEPTH);
    localparam int NH_AW  = $clog2(NEXT_HOP_DEPTH);

    // stage 2: pointer address sum and pointer table access
    logic [15:0]       ptr_sum;
    logic              ptr_ok2, ptr_en, ptr_we;
    logic [PTR_AW-1:0] ptr_addr;
    logic [15:0]       ptr_rdata;

    always_comb
    begin
        ptr_sum  = chunk.base + 16'(chunk.low6) + 16'(chunk.nib);
        ptr_ok2  = {1'b0, ptr_sum} < 17'(POINTER_DEPTH);
        ptr_we   = chunk.req == REQ_PTR_WR;
        ptr_en   = advance && chunk.valid &&
                   ((chunk.req == REQ_LOOKUP && !chunk.direct && ptr_ok2) ||
                    (ptr_we && {1'b0, chunk.idx} < 17'(POINTER_DEPTH)));
        ptr_addr = ptr_we ? chunk.idx[PTR_AW-1:0] : ptr_sum[PTR_AW-1:0];
    end

    lrl_ram #(.WIDTH(16), .DEPTH(POINTER_DEPTH)) u_ptr_ram (
        .clk   (clk),
        .en    (ptr_en),
        .we    (ptr_we),
        .addr  (ptr_addr),
        .wdata (chunk.word),
        .rdata (ptr_rdata)
    );

    // stage 3: pick route, access next-hop table
    logic        v3_reg, direct3_reg, ptr_ok3_reg;
    req_t        req3_reg;
    logic [15:0] idx3_reg;
    logic [31:0] hop3_reg;
    logic [5:0]  low6_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v3_reg <= chunk.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            req3_reg    <= chunk.req;
            idx3_reg    <= chunk.idx;
            hop3_reg    <= chunk.hop;
            direct3_reg <= chunk.direct;
            low6_3_reg  <= chunk.low6;
            ptr_ok3_reg <= ptr_ok2;
        end
    end

    logic [15:0]      route3;
    logic             hop_ok3, nh_en, nh_we;
    logic [NH_AW-1:0] nh_addr;
    logic [31:0]      nh_rdata;

    always_comb
    begin
        if (direct3_reg)
        begin
            route3 = {10'd0, low6_3_reg};
        end
        else if (ptr_ok3_reg)
        begin
            route3 = ptr_rdata;
        end
        else
        begin
            route3 = 16'd0;
        end
        hop_ok3 = {1'b0, route3[HOP_INDEX_W-1:0]} < (HOP_INDEX_W + 1)'(NEXT_HOP_DEPTH);
        nh_we   = req3_reg == REQ_HOP_WR;
        nh_en   = advance && v3_reg &&
                  ((req3_reg == REQ_LOOKUP && hop_ok3) ||
                   (nh_we && {1'b0, idx3_reg} < 17'(NEXT_HOP_DEPTH)));
        nh_addr = nh_we ? idx3_reg[NH_AW-1:0] : route3[NH_AW-1:0];
    end

    lrl_ram #(.WIDTH(32), .DEPTH(NEXT_HOP_DEPTH)) u_nh_ram (
        .clk   (clk),
        .en    (nh_en),
        .we    (nh_we),
        .addr  (nh_addr),
        .wdata (hop3_reg),
        .rdata (nh_rdata)
    );

    // stage 4: only lookups carry on from here
    logic        v4_reg, direct4_reg, hop_ok4_reg;
    logic [15:0] route4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v4_reg <= v3_reg && req3_reg == REQ_LOOKUP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            route4_reg  <= route3;
            direct4_reg <= direct3_reg;
            hop_ok4_reg <= hop_ok3;
        end
    end

    always_comb
    begin
        res.valid   = v4_reg;
        res.gateway = hop_ok4_reg ? nh_rdata : 32'd0;
        res.route   = route4_reg;
        res.direct  = direct4_reg;
    end

endmodule

// ===== rtl/lulea_level1_route_lookup.sv =====
// Level-1 compressed route lookup: five table pipeline with an output skid buffer.
// Depends on lrl_pkg, lrl_front, lrl_back and the assertion macros header.
//
// Accepts one request per clock while the skid slot is free. A lookup's result is
// registered at every stage; table writes use one pipeline slot and give no
// result. Each table is a single-port RAM touched at exactly one pipeline stage, so
// writes and lookups see the tables in request order. Throughput is one item per cycle
// while the master side takes results; a two-entry output buffer lets s_axis_tready
// come straight from a register. Tables are not cleared at reset and must be written
// before they are read.
`include "lulea_level1_route_lookup_macros.svh"

module lulea_level1_route_lookup #(
    parameter int POINTER_DEPTH  = lrl_pkg::DEF_POINTER_DEPTH,
    parameter int NEXT_HOP_DEPTH = lrl_pkg::DEF_NEXT_HOP_DEPTH,
    parameter int MAP_RECORDS    = lrl_pkg::DEF_MAP_RECORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dest_addr[31:0], table_index[47:32], table_word[63:48], hop_value[95:64]
    input  logic [95:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // gateway[31:0], route_index[47:32]
    output logic [47:0] m_axis_tdata,
    // direct_hit[0]
    output logic        m_axis_tuser
);
    import lrl_pkg::*;

    result_t     out_reg, skid_reg;
    result_t     res;
    chunk_item_t chunk;
    req_item_t   in_item;
    logic        advance, in_valid, out_take;

    // the pipeline moves whenever the skid slot is free
    assign advance  = !skid_reg.valid;
    assign in_valid = s_axis_tvalid && advance;
    assign out_take = out_reg.valid && m_axis_tready;

    always_comb
    begin
        in_item.req  = req_t'(s_axis_tuser);
        in_item.dest = s_axis_tdata[31:0];
        in_item.idx  = s_axis_tdata[47:32];
        in_item.word = s_axis_tdata[63:48];
        in_item.hop  = s_axis_tdata[95:64];
    end

    lrl_front #(.MAP_RECORDS(MAP_RECORDS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item),
        .chunk    (chunk)
    );

    lrl_back #(
        .POINTER_DEPTH  (POINTER_DEPTH),
        .NEXT_HOP_DEPTH (NEXT_HOP_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .chunk   (chunk),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (skid_reg.valid)
        begin
            // drain the skid slot once the output register empties
            if (out_take)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (!out_reg.valid || out_take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (out_take)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tdata  = {out_reg.route, out_reg.gateway};
    assign m_axis_tuser  = out_reg.direct;

    `LRL_ASSERT_NOW(a_skid_needs_out, skid_reg.valid, out_reg.valid, "skid full with empty output")
    `LRL_ASSERT_NOW(a_skid_fill, $rose(skid_reg.valid), $past(m_axis_tvalid && !m_axis_tready),
                    "skid filled without a blocked output")
    `LRL_ASSERT_NEXT(a_stall_holds, res.valid && !advance,
                     res.valid && $stable(res.route) && $stable(res.direct),
                     "pipeline result changed during stall")
    `LRL_ASSERT_NOW(a_direct_route, res.valid && res.direct, res.route[15:6] == 10'd0,
                    "direct route index wider than six bits")

endmodule

// ===== sim/route_lookup_checker.sv =====
`timescale 1ns / 100ps
// Checker for the level-1 route lookup: keeps its own copy of the five tables,
// predicts every lookup item and compares the master-side items in order. Needs lrl_pkg.
module route_lookup_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // dest_addr[31:0], table_index[47:32], table_word[63:48], hop_value[95:64]
    input  logic [95:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // gateway[31:0], route_index[47:32]
    input  logic [47:0] m_axis_tdata,
    // direct_hit[0]
    input  logic        m_axis_tuser,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked,
    output int          direct_checked
);
    import lrl_pkg::*;

    typedef struct packed {
        logic [31:0] gateway;
        logic [15:0] route_index;
        logic        direct_hit;
    } route_entry_t;

    logic [15:0] codewords  [CODEWORD_DEPTH];
    logic [15:0] base_words [BASE_DEPTH];
    logic [7:0]  map_bytes  [DEF_MAP_RECORDS * 8];
    logic [15:0] pointers   [DEF_POINTER_DEPTH];
    logic [31:0] next_hops  [DEF_NEXT_HOP_DEPTH];

    route_entry_t pending_routes[$];

    task automatic apply_request(input logic [2:0] kind, input logic [95:0] data);
        logic [31:0]  dest;
        int           idx;
        logic [15:0]  word;
        logic [31:0]  hop;
        logic [15:0]  cw;
        int           rec;
        logic [7:0]   mbyte;
        logic [3:0]   nib;
        logic [15:0]  paddr;
        logic [15:0]  route;
        int           hop_ix;
        route_entry_t res;
        dest = data[31:0];
        idx  = int'(data[47:32]);
        word = data[63:48];
        hop  = data[95:64];
        case (kind)
            REQ_CW_WR:   if (idx < CODEWORD_DEPTH) codewords[idx] = word;
            REQ_BASE_WR: if (idx < BASE_DEPTH) base_words[idx] = word;
            REQ_MAP_WR:  if (idx < DEF_MAP_RECORDS * 8) map_bytes[idx] = word[7:0];
            REQ_PTR_WR:  if (idx < DEF_POINTER_DEPTH) pointers[idx] = word;
            REQ_HOP_WR:  if (idx < DEF_NEXT_HOP_DEPTH) next_hops[idx] = hop;
            REQ_LOOKUP:
            begin
                cw  = codewords[dest[31:20]];
                rec = int'(cw[15:6]);
                if (cw[15:6] == DIRECT_MARK)
                begin
                    route = {10'd0, cw[5:0]};
                    res.direct_hit = 1'b1;
                end
                else
                begin
                    nib = 4'd0;
                    if (rec < DEF_MAP_RECORDS)
                    begin
                        mbyte = map_bytes[rec * 8 + int'(dest[19:17])];
                        // odd positions take the low nibble
                        nib = dest[16] ? mbyte[3:0] : mbyte[7:4];
                    end
                    paddr = base_words[dest[31:22]] + {10'd0, cw[5:0]} + {12'd0, nib};
                    route = (int'(paddr) < DEF_POINTER_DEPTH) ? pointers[paddr] : 16'd0;
                    res.direct_hit = 1'b0;
                end
                hop_ix = int'(route[13:0]);
                res.gateway = (hop_ix < DEF_NEXT_HOP_DEPTH) ? next_hops[hop_ix] : 32'd0;
                res.route_index = route;
                pending_routes.insert(pending_routes.size(), res);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        route_entry_t got;
        route_entry_t want;
        if (!rst_n)
        begin
            mismatches      = 0;
            results_checked = 0;
            direct_checked  = 0;
            pending_routes.delete();
        end
        else
        begin
            // results of this edge come from earlier items, so check before predicting
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tuser};
                if (pending_routes.size() == 0)
                begin
                    $error("unexpected item: gateway %h route_index %h direct_hit %b",
                           got.gateway, got.route_index, got.direct_hit);
                    mismatches++;
                end
                else
                begin
                    want = pending_routes.pop_front();
                    if (got.gateway !== want.gateway)
                    begin
                        $error("gateway: expected %h, actual %h", want.gateway, got.gateway);
                        mismatches++;
                    end
                    if (got.route_index !== want.route_index)
                    begin
                        $error("route_index: expected %h, actual %h",
                               want.route_index, got.route_index);
                        mismatches++;
                    end
                    if (got.direct_hit !== want.direct_hit)
                    begin
                        $error("direct_hit: expected %b, actual %b",
                               want.direct_hit, got.direct_hit);
                        mismatches++;
                    end
                    results_checked++;
                    if (want.direct_hit)
                        direct_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_request(s_axis_tuser, s_axis_tdata);
        end
        outstanding = pending_routes.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the route lookup testbench: clock, reset, request stimulus and verdict.
// Needs lrl_pkg, the lulea_level1_route_lookup RTL and route_lookup_checker.
module tb_top;
    import lrl_pkg::*;

    localparam logic [2:0] REQ_RSVD6      = 3'd6;
    localparam logic [2:0] REQ_RSVD7      = 3'd7;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 950;
    localparam int         POOL_SIZE      = 32;
    localparam logic [7:0] STALL_PATTERN  = 8'b1011_0110;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    int mismatches;
    int outstanding;
    int results_checked;
    int direct_checked;

    int idle_cycles  = 0;
    int burst_left   = 0;
    int stall_mode   = 0;
    int stall_left   = 0;
    int stall_tick   = 0;
    int lookups_sent = 0;
    int writes_sent  = 0;
    int ignored_sent = 0;

    // entries written so far, used only to keep lookups on written entries
    logic [15:0] cw_shadow   [int];
    logic [15:0] base_shadow [int];
    logic [7:0]  map_shadow  [int];
    logic [15:0] ptr_shadow  [int];
    logic [31:0] hop_shadow  [int];
    logic [31:0] dest_pool   [$];

    lulea_level1_route_lookup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    route_lookup_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .direct_checked  (direct_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: switch between free flow, random stalls, heavy stalls and a fixed pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        else
            stall_left = stall_left - 1;
        stall_tick = stall_tick + 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
            default: m_axis_tready <= STALL_PATTERN[stall_tick % 8];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("[lulea_level1_route_lookup] ERROR");
            $finish;
        end
    end

    // called and left at a falling edge; drops valid only when a burst ends
    task automatic send_item(input logic [2:0] kind, input logic [31:0] dest,
                             input logic [15:0] idx, input logic [15:0] word,
                             input logic [31:0] hop);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {hop, word, idx, dest};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic table_write(input logic [2:0] kind, input int idx,
                               input logic [15:0] word, input logic [31:0] hop);
        bit taken;
        taken = 1'b1;
        case (kind)
            REQ_CW_WR:   if (idx < CODEWORD_DEPTH) cw_shadow[idx] = word; else taken = 1'b0;
            REQ_BASE_WR: if (idx < BASE_DEPTH) base_shadow[idx] = word; else taken = 1'b0;
            REQ_MAP_WR:
                if (idx < DEF_MAP_RECORDS * 8) map_shadow[idx] = word[7:0]; else taken = 1'b0;
            REQ_PTR_WR:
                if (idx < DEF_POINTER_DEPTH) ptr_shadow[idx] = word; else taken = 1'b0;
            default:
                if (idx < DEF_NEXT_HOP_DEPTH) hop_shadow[idx] = hop; else taken = 1'b0;
        endcase
        if (taken)
            writes_sent++;
        else
            ignored_sent++;
        send_item(kind, $urandom, 16'(idx), word, hop);
    endtask

    function automatic logic [15:0] random_codeword();
        case ($urandom_range(0, 7))
            0, 1:    return {DIRECT_MARK, 6'($urandom)};
            2:       return {10'(MAP_LAST_RECORD), 6'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // walk the lookup chain and fill every entry it would read before it was written
    task automatic route_lookup(input logic [31:0] dest);
        int          cw_ix;
        int          base_ix;
        int          map_ix;
        int          ptr_ix;
        int          hop_ix;
        logic [15:0] cw;
        logic [15:0] route;
        logic [15:0] paddr;
        logic [7:0]  mbyte;
        logic [3:0]  nib;
        cw_ix   = int'(dest[31:20]);
        base_ix = int'(dest[31:22]);
        if (!cw_shadow.exists(cw_ix))
            table_write(REQ_CW_WR, cw_ix, random_codeword(), $urandom);
        cw = cw_shadow[cw_ix];
        if (cw[15:6] == DIRECT_MARK)
            route = {10'd0, cw[5:0]};
        else
        begin
            if (!base_shadow.exists(base_ix))
                table_write(REQ_BASE_WR, base_ix, 16'($urandom), $urandom);
            map_ix = int'({cw[15:6], dest[19:17]});
            if (!map_shadow.exists(map_ix))
                table_write(REQ_MAP_WR, map_ix, 16'($urandom), $urandom);
            mbyte = map_shadow[map_ix];
            nib   = dest[16] ? mbyte[3:0] : mbyte[7:4];
            paddr = base_shadow[base_ix] + {10'd0, cw[5:0]} + {12'd0, nib};
            ptr_ix = int'(paddr);
            if (!ptr_shadow.exists(ptr_ix))
                table_write(REQ_PTR_WR, ptr_ix, 16'($urandom), $urandom);
            route = ptr_shadow[ptr_ix];
        end
        hop_ix = int'(route[13:0]);
        if (!hop_shadow.exists(hop_ix))
            table_write(REQ_HOP_WR, hop_ix, 16'($urandom), $urandom);
        send_item(REQ_LOOKUP, dest, 16'($urandom), 16'($urandom), $urandom);
        lookups_sent++;
        if (dest_pool.size() < POOL_SIZE)
            dest_pool.insert(dest_pool.size(), dest);
        else
            dest_pool[$urandom_range(0, POOL_SIZE - 1)] = dest;
    endtask

    initial
    begin
        int          sel;
        int          directed_items;
        logic [2:0]  kind;
        logic [31:0] dest;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // direct mark with the all-ones destination and next-hop slot 63
        table_write(REQ_CW_WR, 12'hfff, {DIRECT_MARK, 6'h3f}, $urandom);
        table_write(REQ_HOP_WR, 63, 16'($urandom), 32'hffff_ffff);
        route_lookup(32'hffff_ffff);
        // base + offset + nibble wraps past 16 bits; route index above 14 bits
        table_write(REQ_CW_WR, 0, 16'h0000, $urandom);
        table_write(REQ_BASE_WR, 0, 16'hffff, $urandom);
        table_write(REQ_MAP_WR, 0, 16'hfff0, $urandom);
        table_write(REQ_PTR_WR, 16'h000e, 16'hffff, $urandom);
        table_write(REQ_HOP_WR, 16'h3fff, 16'h0000, 32'h0000_0000);
        route_lookup(32'h0000_0000);
        table_write(REQ_PTR_WR, 16'hffff, 16'hc000, $urandom);
        table_write(REQ_HOP_WR, 0, 16'h0000, 32'h8000_0001);
        route_lookup(32'h0001_0000);
        // last map record and byte, the last regular record, and one past the mark
        table_write(REQ_CW_WR, 12'h800, {10'd1023, 6'd0}, $urandom);
        table_write(REQ_MAP_WR, DEF_MAP_RECORDS * 8 - 1, 16'h000f, $urandom);
        route_lookup(32'h800e_0000);
        table_write(REQ_CW_WR, 12'h7ff, {10'(MAP_LAST_RECORD), 6'h15}, $urandom);
        route_lookup(32'h7ff5_a5a5);
        table_write(REQ_CW_WR, 12'h123, {10'(DIRECT_MARK + 1), 6'h00}, $urandom);
        route_lookup(32'h1238_0000);
        // unknown requests and writes just past the codeword, base, map and next-hop tables; none may alias entry 0
        send_item(REQ_RSVD6, $urandom, 16'($urandom), 16'($urandom), $urandom);
        send_item(REQ_RSVD7, $urandom, 16'($urandom), 16'($urandom), $urandom);
        ignored_sent += 2;
        table_write(REQ_CW_WR, CODEWORD_DEPTH, {DIRECT_MARK, 6'h01}, $urandom);
        table_write(REQ_BASE_WR, BASE_DEPTH, 16'h1234, $urandom);
        table_write(REQ_MAP_WR, DEF_MAP_RECORDS * 8, 16'h0055, $urandom);
        table_write(REQ_HOP_WR, DEF_NEXT_HOP_DEPTH, 16'h0000, 32'hdead_beef);
        table_write(REQ_CW_WR, 16'hffff, 16'hffff, $urandom);
        route_lookup(32'h0000_0000);
        route_lookup(32'h0001_0000);
        directed_items = lookups_sent + writes_sent + ignored_sent;

        while (lookups_sent + writes_sent + ignored_sent < directed_items + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                // mostly revisit known prefixes at new positions
                if ($urandom_range(0, 9) < 6)
                    dest = dest_pool[$urandom_range(0, dest_pool.size() - 1)]
                           ^ ($urandom & 32'h000f_ffff);
                else
                    dest = $urandom;
                route_lookup(dest);
            end
            else if (sel < 88)
            begin
                kind = 3'($urandom_range(REQ_CW_WR, REQ_HOP_WR));
                dest = dest_pool[$urandom_range(0, dest_pool.size() - 1)];
                case (kind)
                    REQ_CW_WR:
                        table_write(kind, $urandom_range(0, 1) ? int'(dest[31:20])
                                    : $urandom_range(0, CODEWORD_DEPTH - 1),
                                    random_codeword(), $urandom);
                    REQ_BASE_WR:
                        table_write(kind, $urandom_range(0, 1) ? int'(dest[31:22])
                                    : $urandom_range(0, BASE_DEPTH - 1),
                                    16'($urandom), $urandom);
                    REQ_MAP_WR:
                        table_write(kind, $urandom_range(0, DEF_MAP_RECORDS * 8 - 1),
                                    16'($urandom), $urandom);
                    REQ_PTR_WR:
                        table_write(kind, $urandom_range(0, DEF_POINTER_DEPTH - 1),
                                    16'($urandom), $urandom);
                    default:
                        table_write(kind, $urandom_range(0, DEF_NEXT_HOP_DEPTH - 1),
                                    16'($urandom), $urandom);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                    begin
                        kind = $urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7;
                        send_item(kind, $urandom, 16'($urandom), 16'($urandom), $urandom);
                        ignored_sent++;
                    end
                    2: table_write(REQ_CW_WR, $urandom_range(CODEWORD_DEPTH, 65535),
                                   16'($urandom), $urandom);
                    3: table_write(REQ_BASE_WR, $urandom_range(BASE_DEPTH, 65535),
                                   16'($urandom), $urandom);
                    4: table_write(REQ_MAP_WR, $urandom_range(DEF_MAP_RECORDS * 8, 65535),
                                   16'($urandom), $urandom);
                    default: table_write(REQ_HOP_WR, $urandom_range(DEF_NEXT_HOP_DEPTH, 65535),
                                         16'($urandom), $urandom);
                endcase
            end
        end
        s_axis_tvalid <= 1'b0;

        wait (outstanding == 0);
        repeat (12) @(posedge clk);
        $display("Run covered %0d lookups, %0d table writes and %0d ignored requests.",
                 lookups_sent, writes_sent, ignored_sent);
        $display("Compared %0d lookup results, %0d of them direct hits.",
                 results_checked, direct_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("[lulea_level1_route_lookup] OK");
        else
            $display("[lulea_level1_route_lookup] ERROR");
        $finish;
    end

endmodule
